>>> hw/rtl/gbi_pkg.sv
// Shared types, widths and command codes of the gravity body integrator.
package gbi_pkg;

  localparam int unsigned CoordW  = 48;
  localparam int unsigned FracW   = 16;
  localparam int unsigned MassW   = 48;
  localparam int unsigned GravW   = 32;
  localparam int unsigned StepW   = 32;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 2;

  // Sum of three squared separations and its integer root.
  localparam int unsigned SqW     = 2 * CoordW + 2;
  localparam int unsigned RootW   = SqW / 2;
  localparam int unsigned SqRemW  = RootW + 3;

  // Shift-add multiplier and restoring divider operand widths.
  localparam int unsigned MulAW   = 192;
  localparam int unsigned MulBW   = 48;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned DivNW   = 192;
  localparam int unsigned DivDW   = SqW + 16;
  localparam int unsigned ForceW  = 144;

  localparam int unsigned MulCntW  = $clog2(MulBW + 1);
  localparam int unsigned DivCntW  = $clog2(DivNW + 1);
  localparam int unsigned SqrtCntW = $clog2(RootW + 1);

  localparam int unsigned AccShift = 80 - FracW;
  localparam int unsigned AdvShift = 16;

  localparam logic [MassW-1:0] OwnMassRst = 48'd1;
  localparam logic [GravW-1:0] GravRst    = 32'd80687100;
  localparam logic [StepW-1:0] StepRst    = 32'd65536;

  localparam logic [CfgIdxW-1:0] CFG_OWN_MASS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRAV     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP     = 2'd2;

  localparam logic [1:0] REQ_PULL    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_LOAD    = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
    logic signed [CoordW-1:0] vel_z;
    logic [MassW-1:0]         other_mass;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] body_x;
    logic signed [CoordW-1:0] body_y;
    logic signed [CoordW-1:0] body_z;
    logic signed [CoordW-1:0] body_vx;
    logic signed [CoordW-1:0] body_vy;
    logic signed [CoordW-1:0] body_vz;
    logic                     coincident;
    logic                     saturated;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_SQ,
    OP_ADD_S,
    OP_SET_COIN,
    OP_SQRT,
    OP_MUL_GM,
    OP_MUL_NO,
    OP_DIV_F,
    OP_SAVE_F,
    OP_MUL_FM,
    OP_DIV_D,
    OP_DIV_M,
    OP_MUL_ST,
    OP_SAT_V,
    OP_MUL_ADV,
    OP_SAT_P,
    OP_LOAD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       mul_busy;
    logic       div_busy;
    logic       sqrt_busy;
    logic       s_zero;
  } sts_t;

endpackage

>>> hw/rtl/gravity_body_integrator.sv
// Top level: one body's position and velocity under Newtonian pulls.
// The time a pull request takes is set mostly by the shared restoring divider
// (one quotient bit per cycle over 192 bits, seven divisions' worth of work).
// One request is in work at a time; a result waits in an output register.
// Reset clears position and velocity and restores mass 1, the scaled
// gravitational constant and a unit time step.
module gravity_body_integrator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gbi_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gbi_pkg::rsp_t                out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [gbi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gbi_pkg::CfgW-1:0]     cfg_wdata_i
);
  import gbi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

>>> hw/rtl/gbi_mul.sv
// Shift-add multiplier, one multiplier bit per cycle from the top bit down.
module gbi_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gbi_pkg::MulAW-1:0]  a_i,
  input  logic [gbi_pkg::MulBW-1:0]  b_i,
  output logic                       busy_o,
  output logic [gbi_pkg::ProdW-1:0]  prod_o
);
  import gbi_pkg::*;

  logic               busy_q;
  logic [MulCntW-1:0] cnt_q;
  logic [MulAW-1:0]   a_q;
  logic [MulBW-1:0]   b_q;
  logic [ProdW-1:0]   p_q, p_d;

  assign p_d = {p_q[ProdW-2:0], 1'b0}
             + (b_q[MulBW-1] ? {{MulBW{1'b0}}, a_q} : {ProdW{1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= MulCntW'(MulBW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == MulCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[MulBW-2:0], 1'b0};
      p_q <= p_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = p_q;

endmodule

>>> hw/rtl/gbi_div.sv
// Restoring divider, one quotient bit per cycle.
module gbi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gbi_pkg::DivNW-1:0]  num_i,
  input  logic [gbi_pkg::DivDW-1:0]  den_i,
  output logic                       busy_o,
  output logic [gbi_pkg::DivNW-1:0]  quo_o
);
  import gbi_pkg::*;

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNW-1:0]   nq_q;
  logic [DivDW-1:0]   rem_q, den_q, rem_d;
  logic [DivDW:0]     shifted, diff;
  logic               ge;

  assign shifted = {rem_q, nq_q[DivNW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};
  assign rem_d   = ge ? diff[DivDW-1:0] : shifted[DivDW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(DivNW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      nq_q  <= {nq_q[DivNW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = nq_q;

endmodule

>>> hw/rtl/gbi_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module gbi_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gbi_pkg::SqW-1:0]    rad_i,
  output logic                       busy_o,
  output logic [gbi_pkg::RootW-1:0]  root_o
);
  import gbi_pkg::*;

  logic                busy_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic [SqW-1:0]      rad_q;
  logic [RootW-1:0]    root_q;
  logic [SqRemW-1:0]   rem_q, rem_sh, trial;
  logic                ge;

  assign rem_sh = {rem_q[SqRemW-3:0], rad_q[SqW-1:SqW-2]};
  assign trial  = SqRemW'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= SqrtCntW'(RootW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == SqrtCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqW-3:0], 2'b00};
      root_q <= {root_q[RootW-2:0], ge};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/gbi_dp.sv
// Datapath: body state, configuration, arithmetic units and result register.
module gbi_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gbi_pkg::CfgW-1:0]     cfg_wdata_i,
  input  gbi_pkg::req_t                in_req_i,
  input  gbi_pkg::cmd_t                cmd_i,
  output gbi_pkg::sts_t                sts_o,
  output gbi_pkg::rsp_t                out_rsp_o
);
  import gbi_pkg::*;

  logic signed [CoordW-1:0] pos_q [3];
  logic signed [CoordW-1:0] vel_q [3];
  logic [MassW-1:0]         own_mass_q;
  logic [GravW-1:0]         grav_q;
  logic [StepW-1:0]         step_q;
  logic                     coin_q, sat_q;

  req_t                     req_q;
  logic [CoordW-1:0]        mag_q [3];
  logic                     neg_q [3];
  logic [SqW-1:0]           s_q;
  logic [ForceW-1:0]        force_q;
  rsp_t                     out_q;

  logic [CoordW-1:0]        other [3];
  logic [CoordW-1:0]        new_mag [3];
  logic                     new_neg [3];
  logic [MassW-1:0]         m1;
  logic [CoordW-1:0]        vmag;

  logic                     mul_start, div_start, sqrt_start;
  logic [MulAW-1:0]         mul_a;
  logic [MulBW-1:0]         mul_b;
  logic [ProdW-1:0]         prod;
  logic [DivNW-1:0]         div_n, quo;
  logic [DivDW-1:0]         div_d;
  logic [RootW-1:0]         root;
  logic                     mul_busy, div_busy, sqrt_busy;

  logic [CoordW:0]          sat_v, sat_p;

  // Adds or subtracts a magnitude, clamping to the signed coordinate range.
  function automatic logic [CoordW:0] sat_add(input logic [CoordW-1:0] a,
                                              input logic neg,
                                              input logic big,
                                              input logic [CoordW-1:0] m);
    logic [CoordW-1:0] room;
    logic [CoordW-1:0] res;
    logic              over;
    room = {~a[CoordW-1], a[CoordW-2:0]};
    if (!neg) begin
      room = ~room;
    end
    over = big || (m > room);
    if (over) begin
      res = neg ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      res = neg ? a - m : a + m;
    end
    return {over, res};
  endfunction

  assign other[0] = in_req_i.pos_x;
  assign other[1] = in_req_i.pos_y;
  assign other[2] = in_req_i.pos_z;

  always_comb begin
    logic [CoordW:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff       = {other[i][CoordW-1], other[i]} - {pos_q[i][CoordW-1], pos_q[i]};
      new_neg[i] = diff[CoordW];
      new_mag[i] = diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];
    end
  end

  assign m1   = (own_mass_q == '0) ? MassW'(1) : own_mass_q;
  assign vmag = vel_q[cmd_i.idx][CoordW-1] ? CoordW'(-vel_q[cmd_i.idx])
                                           : vel_q[cmd_i.idx];

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd_i.op)
      OP_MUL_SQ: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(mag_q[cmd_i.idx]);
        mul_b     = MulBW'(mag_q[cmd_i.idx]);
      end
      OP_MUL_GM: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(grav_q);
        mul_b     = MulBW'(m1);
      end
      OP_MUL_NO: begin
        mul_start = 1'b1;
        mul_a     = prod[MulAW-1:0];
        mul_b     = MulBW'(req_q.other_mass);
      end
      OP_MUL_FM: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(force_q);
        mul_b     = MulBW'(mag_q[cmd_i.idx]);
      end
      OP_MUL_ST: begin
        mul_start = 1'b1;
        mul_a     = quo;
        mul_b     = MulBW'(step_q);
      end
      OP_MUL_ADV: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(vmag);
        mul_b     = MulBW'(step_q);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd_i.op)
      OP_DIV_F: begin
        // Force numerator carries 2*FracW extra fraction bits.
        div_start = 1'b1;
        div_n     = DivNW'({prod[2*CoordW+GravW-1:0], {(2*FracW){1'b0}}});
        div_d     = {s_q, 16'b0};
      end
      OP_DIV_D: begin
        div_start = 1'b1;
        div_n     = prod[DivNW-1:0];
        div_d     = DivDW'(root);
      end
      OP_DIV_M: begin
        div_start = 1'b1;
        div_n     = quo;
        div_d     = DivDW'(m1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (cmd_i.op == OP_SQRT);

  gbi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  gbi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  gbi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (s_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign sat_v = sat_add(vel_q[cmd_i.idx], neg_q[cmd_i.idx],
                         |prod[ProdW-1:AccShift+CoordW],
                         prod[AccShift+CoordW-1:AccShift]);
  assign sat_p = sat_add(pos_q[cmd_i.idx], vmag != vel_q[cmd_i.idx] ? 1'b1 :
                         vel_q[cmd_i.idx][CoordW-1],
                         |prod[ProdW-1:AdvShift+CoordW],
                         prod[AdvShift+CoordW-1:AdvShift]);

  // Body state, configuration and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      own_mass_q <= OwnMassRst;
      grav_q     <= GravRst;
      step_q     <= StepRst;
      coin_q     <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_OWN_MASS: own_mass_q <= cfg_wdata_i[MassW-1:0];
          CFG_GRAV:     grav_q     <= cfg_wdata_i[GravW-1:0];
          CFG_STEP:     step_q     <= cfg_wdata_i[StepW-1:0];
          default:      ;
        endcase
      end
      case (cmd_i.op)
        OP_LATCH: begin
          coin_q <= 1'b0;
          sat_q  <= 1'b0;
        end
        OP_SET_COIN: coin_q <= (s_q == '0);
        OP_SAT_V: begin
          vel_q[cmd_i.idx] <= sat_v[CoordW-1:0];
          sat_q            <= sat_q | sat_v[CoordW];
        end
        OP_SAT_P: begin
          pos_q[cmd_i.idx] <= sat_p[CoordW-1:0];
          sat_q            <= sat_q | sat_p[CoordW];
        end
        OP_LOAD: begin
          pos_q[0] <= req_q.pos_x;
          pos_q[1] <= req_q.pos_y;
          pos_q[2] <= req_q.pos_z;
          vel_q[0] <= req_q.vel_x;
          vel_q[1] <= req_q.vel_y;
          vel_q[2] <= req_q.vel_z;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the current request and the result register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        req_q <= in_req_i;
        s_q   <= '0;
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= new_mag[i];
          neg_q[i] <= new_neg[i];
        end
      end
      OP_ADD_S:  s_q     <= s_q + SqW'(prod[2*CoordW-1:0]);
      OP_SAVE_F: force_q <= quo[ForceW-1:0];
      OP_OUT: begin
        out_q.body_x     <= pos_q[0];
        out_q.body_y     <= pos_q[1];
        out_q.body_z     <= pos_q[2];
        out_q.body_vx    <= vel_q[0];
        out_q.body_vy    <= vel_q[1];
        out_q.body_vz    <= vel_q[2];
        out_q.coincident <= coin_q;
        out_q.saturated  <= sat_q;
      end
      default: ;
    endcase
  end

  assign sts_o.req_type  = req_q.req_type;
  assign sts_o.mul_busy  = mul_busy;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.sqrt_busy = sqrt_busy;
  assign sts_o.s_zero    = (s_q == '0);
  assign out_rsp_o       = out_q;

endmodule

>>> hw/rtl/gbi_ctrl.sv
// Controller: sequences the datapath through pull, advance and load requests.
module gbi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gbi_pkg::sts_t sts_i,
  output gbi_pkg::cmd_t cmd_o
);
  import gbi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_SQ_GO, S_SQ_WAIT, S_ADD_S, S_CHECK_S,
    S_SQRT_GO, S_SQRT_WAIT,
    S_GM_GO, S_GM_WAIT, S_NO_GO, S_NO_WAIT,
    S_DIVF_GO, S_DIVF_WAIT, S_SAVE_F,
    S_FM_GO, S_FM_WAIT, S_DD_GO, S_DD_WAIT, S_DM_GO, S_DM_WAIT,
    S_ST_GO, S_ST_WAIT, S_SAT_V,
    S_ADV_GO, S_ADV_WAIT, S_SAT_P,
    S_LOAD, S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign last        = (idx_q == 2'd2);
  assign cmd_o.idx   = idx_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_d = '0;
        unique case (sts_i.req_type)
          REQ_PULL:    state_d = S_SQ_GO;
          REQ_ADVANCE: state_d = S_ADV_GO;
          REQ_LOAD:    state_d = S_LOAD;
          default:     state_d = S_FINISH;
        endcase
      end
      S_SQ_GO: begin
        cmd_o.op = OP_MUL_SQ;
        state_d  = S_SQ_WAIT;
      end
      S_SQ_WAIT: if (!sts_i.mul_busy) state_d = S_ADD_S;
      S_ADD_S: begin
        cmd_o.op = OP_ADD_S;
        if (last) begin
          idx_d   = '0;
          state_d = S_CHECK_S;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SQ_GO;
        end
      end
      S_CHECK_S: begin
        // Coincident bodies leave the state untouched.
        cmd_o.op = OP_SET_COIN;
        state_d  = sts_i.s_zero ? S_FINISH : S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd_o.op = OP_SQRT;
        state_d  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: if (!sts_i.sqrt_busy) state_d = S_GM_GO;
      S_GM_GO: begin
        cmd_o.op = OP_MUL_GM;
        state_d  = S_GM_WAIT;
      end
      S_GM_WAIT: if (!sts_i.mul_busy) state_d = S_NO_GO;
      S_NO_GO: begin
        cmd_o.op = OP_MUL_NO;
        state_d  = S_NO_WAIT;
      end
      S_NO_WAIT: if (!sts_i.mul_busy) state_d = S_DIVF_GO;
      S_DIVF_GO: begin
        cmd_o.op = OP_DIV_F;
        state_d  = S_DIVF_WAIT;
      end
      S_DIVF_WAIT: if (!sts_i.div_busy) state_d = S_SAVE_F;
      S_SAVE_F: begin
        cmd_o.op = OP_SAVE_F;
        state_d  = S_FM_GO;
      end
      S_FM_GO: begin
        cmd_o.op = OP_MUL_FM;
        state_d  = S_FM_WAIT;
      end
      S_FM_WAIT: if (!sts_i.mul_busy) state_d = S_DD_GO;
      S_DD_GO: begin
        cmd_o.op = OP_DIV_D;
        state_d  = S_DD_WAIT;
      end
      S_DD_WAIT: if (!sts_i.div_busy) state_d = S_DM_GO;
      S_DM_GO: begin
        cmd_o.op = OP_DIV_M;
        state_d  = S_DM_WAIT;
      end
      S_DM_WAIT: if (!sts_i.div_busy) state_d = S_ST_GO;
      S_ST_GO: begin
        cmd_o.op = OP_MUL_ST;
        state_d  = S_ST_WAIT;
      end
      S_ST_WAIT: if (!sts_i.mul_busy) state_d = S_SAT_V;
      S_SAT_V: begin
        cmd_o.op = OP_SAT_V;
        if (last) begin
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FM_GO;
        end
      end
      S_ADV_GO: begin
        cmd_o.op = OP_MUL_ADV;
        state_d  = S_ADV_WAIT;
      end
      S_ADV_WAIT: if (!sts_i.mul_busy) state_d = S_SAT_P;
      S_SAT_P: begin
        cmd_o.op = OP_SAT_P;
        if (last) begin
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ADV_GO;
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        // The result register takes a new result once the old one is gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> tb/gravity_body_integrator_tb.sv
// Self-checking testbench of the gravity body integrator: directed and random requests.
`timescale 1ns / 100ps

module gravity_body_integrator_tb;
  import gbi_pkg::*;

  typedef logic [255:0] u256_t;
  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t rsp;
  } dir_row_t;

  localparam logic [1:0] REQ_IDLE = 2'd3;
  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned NumPhases = 7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  gravity_body_integrator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Body state and registers as the block should hold them.
  coord_t body_pos[3];
  coord_t body_vel[3];
  logic [MassW-1:0] own_mass;
  logic [GravW-1:0] grav_const;
  logic [StepW-1:0] step_size;

  rsp_t state_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_pull, n_adv, n_load, n_coin, n_sat, n_rsp;
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, state_q.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic coord_t clamp_add(coord_t a, bit neg, u256_t m, inout bit sat);
    logic signed [259:0] sa;
    logic signed [259:0] sm;
    logic signed [259:0] t;
    logic signed [259:0] hi;
    logic signed [259:0] lo;
    sa = a;
    sm = $signed({4'b0, m});
    hi = CoordMax;
    lo = CoordMin;
    t = neg ? sa - sm : sa + sm;
    if (t > hi) begin
      sat = 1'b1;
      return CoordMax;
    end
    if (t < lo) begin
      sat = 1'b1;
      return CoordMin;
    end
    return t[CoordW-1:0];
  endfunction

  function automatic u256_t int_root(u256_t s);
    u256_t r;
    u256_t t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (u256_t'(1) << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Applies one request to the body state and returns the state after it.
  function automatic rsp_t integrate(req_t r);
    rsp_t o;
    coord_t other[3];
    u256_t mag[3];
    bit neg[3];
    u256_t s, d, num, fmag, fc, acc, dv, m1;
    logic signed [CoordW:0] diff;
    bit sat, coin;
    other = '{r.pos_x, r.pos_y, r.pos_z};
    sat = 1'b0;
    coin = 1'b0;
    case (r.req_type)
      REQ_PULL: begin
        n_pull++;
        m1 = (own_mass == '0) ? u256_t'(1) : u256_t'(own_mass);
        s = '0;
        for (int i = 0; i < 3; i++) begin
          diff = $signed(other[i]) - $signed(body_pos[i]);
          neg[i] = diff < 0;
          if (neg[i]) diff = -diff;
          mag[i] = u256_t'($unsigned(diff));
          s = s + mag[i] * mag[i];
        end
        if (s == '0) begin
          coin = 1'b1;
        end else begin
          d = int_root(s);
          num = (u256_t'(grav_const) * m1 * u256_t'(r.other_mass)) << (2 * FracW);
          fmag = num / (s << 16);
          for (int i = 0; i < 3; i++) begin
            fc = (fmag * mag[i]) / d;
            acc = fc / m1;
            dv = (acc * u256_t'(step_size)) >> AccShift;
            body_vel[i] = clamp_add(body_vel[i], neg[i], dv, sat);
          end
        end
      end
      REQ_ADVANCE: begin
        n_adv++;
        for (int i = 0; i < 3; i++) begin
          diff = body_vel[i];
          if (body_vel[i] < 0) diff = -diff;
          dv = (u256_t'($unsigned(diff)) * u256_t'(step_size)) >> AdvShift;
          body_pos[i] = clamp_add(body_pos[i], body_vel[i] < 0, dv, sat);
        end
      end
      REQ_LOAD: begin
        n_load++;
        body_pos = '{r.pos_x, r.pos_y, r.pos_z};
        body_vel = '{r.vel_x, r.vel_y, r.vel_z};
      end
      default: ;
    endcase
    n_coin += coin;
    n_sat += sat;
    o.body_x = body_pos[0];
    o.body_y = body_pos[1];
    o.body_z = body_pos[2];
    o.body_vx = body_vel[0];
    o.body_vy = body_vel[1];
    o.body_vz = body_vel[2];
    o.coincident = coin;
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic [47:0] rnd48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic coord_t rnd_coord();
    coord_t v;
    v = rnd48();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? CoordMax : CoordMin;
    return v >>> $urandom_range(0, CoordW - 1);
  endfunction

  function automatic req_t make_request();
    req_t r;
    int unsigned sel;
    coord_t here[3];
    coord_t off;
    r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 99);
    here = body_pos;
    if (sel < 8) return r;
    if (sel < 30) begin
      r.req_type = REQ_LOAD;
      r.pos_x = rnd_coord();
      r.pos_y = rnd_coord();
      r.pos_z = rnd_coord();
      r.vel_x = rnd_coord();
      r.vel_y = rnd_coord();
      r.vel_z = rnd_coord();
    end else if (sel < 60) begin
      r.req_type = REQ_PULL;
      // Another body near this one, on a random scale; now and then on top of it.
      if ($urandom_range(0, 19) == 0) begin
        r.pos_x = here[0];
        r.pos_y = here[1];
        r.pos_z = here[2];
      end else begin
        off = rnd48() >>> $urandom_range(1, CoordW - 1);
        r.pos_x = here[0] + off;
        off = rnd48() >>> $urandom_range(1, CoordW - 1);
        r.pos_y = here[1] + off;
        off = rnd48() >>> $urandom_range(1, CoordW - 1);
        r.pos_z = here[2] + off;
      end
      r.other_mass = rnd48() >> $urandom_range(0, MassW - 1);
    end else begin
      r.req_type = REQ_ADVANCE;
    end
    return r;
  endfunction

  // Drives one request; valid stays high across back-to-back requests.
  task automatic send(req_t r, bit known, rsp_t rsp);
    int unsigned gap;
    rsp_t exp_rsp;
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    exp_rsp = integrate(r);
    state_q.push_back(known ? rsp : exp_rsp);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OWN_MASS: own_mass = val[MassW-1:0];
      CFG_GRAV:     grav_const = val[GravW-1:0];
      CFG_STEP:     step_size = val[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (state_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Result side: random stall before each result, with calm stretches too.
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_rsp++;
      if (state_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_rsp_o);
        errors++;
      end else begin
        e = state_q.pop_front();
        if (e != out_rsp_o) begin
          errors++;
          if (e.body_x != out_rsp_o.body_x)
            $display("%0t body_x exp %0d got %0d", $time, e.body_x, out_rsp_o.body_x);
          if (e.body_y != out_rsp_o.body_y)
            $display("%0t body_y exp %0d got %0d", $time, e.body_y, out_rsp_o.body_y);
          if (e.body_z != out_rsp_o.body_z)
            $display("%0t body_z exp %0d got %0d", $time, e.body_z, out_rsp_o.body_z);
          if (e.body_vx != out_rsp_o.body_vx)
            $display("%0t body_vx exp %0d got %0d", $time, e.body_vx, out_rsp_o.body_vx);
          if (e.body_vy != out_rsp_o.body_vy)
            $display("%0t body_vy exp %0d got %0d", $time, e.body_vy, out_rsp_o.body_vy);
          if (e.body_vz != out_rsp_o.body_vz)
            $display("%0t body_vz exp %0d got %0d", $time, e.body_vz, out_rsp_o.body_vz);
          if (e.coincident != out_rsp_o.coincident)
            $display("%0t coincident exp %0d got %0d", $time, e.coincident,
                     out_rsp_o.coincident);
          if (e.saturated != out_rsp_o.saturated)
            $display("%0t saturated exp %0d got %0d", $time, e.saturated,
                     out_rsp_o.saturated);
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [CfgW-1:0] phase_regs[NumPhases][3];
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_OWN_MASS;
    cfg_wdata_i <= '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    body_pos = '{default: '0};
    body_vel = '{default: '0};
    own_mass = OwnMassRst;
    grav_const = GravRst;
    step_size = StepRst;
    phase_regs = '{'{48'd1, 48'hFFFF_FFFF, 48'd65536},
                   '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF},
                   '{48'd0, 48'd80687100, 48'd0},
                   '{48'd1, 48'd0, 48'hFFFF_FFFF},
                   '{48'd3, 48'hFFFF_FFFF, 48'd1048576},
                   '{48'd1000, 48'h8000_0000, 48'd65536},
                   '{48'd1, 48'd80687100, 48'd65536}};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: expectation typed in where it is plain, else predicted.
    row = '{default: '0};
    row.req.req_type = REQ_ADVANCE;
    row.known = 1'b1;
    rows.push_back(row);
    row.req = '1;
    row.req.req_type = REQ_IDLE;
    rows.push_back(row);
    row.req = '0;
    row.req.req_type = REQ_PULL;
    row.req.other_mass = '1;
    row.rsp.coincident = 1'b1;
    rows.push_back(row);
    row.req = '0;
    row.req.req_type = REQ_LOAD;
    row.req.pos_x = CoordMax; row.req.pos_y = CoordMax; row.req.pos_z = CoordMax;
    row.req.vel_x = CoordMax; row.req.vel_y = CoordMax; row.req.vel_z = CoordMax;
    row.rsp = '{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, 1'b0, 1'b0};
    rows.push_back(row);
    row.req.pos_x = CoordMin; row.req.pos_y = CoordMin; row.req.pos_z = CoordMin;
    row.req.vel_x = CoordMin; row.req.vel_y = CoordMin; row.req.vel_z = CoordMin;
    row.rsp = '{CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, 1'b0, 1'b0};
    rows.push_back(row);
    // Most negative velocity over one unit step pushes past the lower limit.
    row.req = '0;
    row.req.req_type = REQ_ADVANCE;
    row.rsp.saturated = 1'b1;
    rows.push_back(row);
    row = '{default: '0};
    row.req.req_type = REQ_LOAD;
    row.req.vel_x = CoordMax; row.req.vel_y = -48'sd65536; row.req.vel_z = 48'sd1;
    rows.push_back(row);
    row.req = '0;
    row.req.req_type = REQ_ADVANCE;
    rows.push_back(row);
    rows.push_back(row);
    row.req = '0;
    row.req.req_type = REQ_LOAD;
    rows.push_back(row);
    row.req.req_type = REQ_PULL;
    row.req.pos_x = 48'sd65536;
    row.req.other_mass = '1;
    rows.push_back(row);
    row.req.pos_x = CoordMin; row.req.pos_y = CoordMax; row.req.pos_z = -48'sd1;
    rows.push_back(row);
    row.req.pos_x = 48'sd1; row.req.pos_y = 48'sd1; row.req.pos_z = 48'sd1;
    rows.push_back(row);
    row.req.other_mass = '0;
    rows.push_back(row);
    row.req = '1;
    row.req.req_type = REQ_PULL;
    rows.push_back(row);
    row.req.req_type = REQ_IDLE;
    rows.push_back(row);

    foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].rsp);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(CFG_OWN_MASS, phase_regs[p][0]);
      write_reg(CFG_GRAV, phase_regs[p][1]);
      write_reg(CFG_STEP, phase_regs[p][2]);
      for (int k = 0; k < ItemsPerPhase; k++) send(make_request(), 1'b0, '0);
    end
    drain();
    repeat (100) @(posedge clk_i);

    $display("Covered %0d pulls, %0d advances, %0d loads over %0d register settings;",
             n_pull, n_adv, n_load, NumPhases + 1);
    $display("%0d results checked, %0d coincident, %0d saturated, %0d mismatches.",
             n_rsp, n_coin, n_sat, errors);
    if (errors == 0 && state_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gbi_pkg.sv
hw/rtl/gbi_mul.sv
hw/rtl/gbi_div.sv
hw/rtl/gbi_sqrt.sv
hw/rtl/gbi_dp.sv
hw/rtl/gbi_ctrl.sv
hw/rtl/gravity_body_integrator.sv
tb/gravity_body_integrator_tb.sv
